// ----- rtl/kth_permutation_unrank_macros.svh -----
// Assertion macros shared by the permutation unranking RTL.
// Files that check their own logic include this header; it depends on nothing.
`ifndef KTH_PERMUTATION_UNRANK_MACROS_SVH
`define KTH_PERMUTATION_UNRANK_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define KPU_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define KPU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kpu_pkg.sv -----
// Shared types, constants and the factorial table for the permutation unranker.
// Depends on nothing; every RTL module imports it.
`default_nettype none

package kpu_pkg;

    localparam int MAX_LEN   = 16;
    localparam int LEN_W     = 5;
    localparam int RANK_W    = 31;
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int FACT_W    = RANK_W + 1;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [RANK_W-1:0] rank;
    } query_t;

    typedef struct packed {
        logic [LEN_W-1:0] element;
        logic             out_of_range;
        logic             last;
    } result_t;

    // Classified request as it waits between front and back
    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [RANK_W-1:0] rem;
        logic              err;
    } job_t;

    // n!, saturated to 2^31: anything larger exceeds every possible rank
    function automatic logic [FACT_W-1:0] fact_sat(input logic [LEN_W-1:0] n);
        logic [FACT_W-1:0] f;
        case (n) inside
            5'd0, 5'd1: f = 32'd1;
            5'd2:       f = 32'd2;
            5'd3:       f = 32'd6;
            5'd4:       f = 32'd24;
            5'd5:       f = 32'd120;
            5'd6:       f = 32'd720;
            5'd7:       f = 32'd5040;
            5'd8:       f = 32'd40320;
            5'd9:       f = 32'd362880;
            5'd10:      f = 32'd3628800;
            5'd11:      f = 32'd39916800;
            5'd12:      f = 32'd479001600;
            default:    f = 32'h8000_0000;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kth_permutation_unrank.sv -----
// Top level of the lexicographic permutation unranker: front end, job queue, digit engine.
// Depends on kpu_pkg, kpu_front, kpu_queue and kpu_back.
`default_nettype none

// Each request (length n, one-based rank k) yields the k-th permutation of 1..n in
// lexicographic order, one element per result, with last set on the n-th. A rank of
// zero, a rank above n!, or a length outside 1..16 gives one result with element 0,
// out_of_range and last set. Requests are checked on entry and wait in a two-entry
// queue, so a new request is taken while the previous one is still being worked out.
// The digit engine finds each digit by repeated compare and subtract, stepping over
// one factorial block at a time before it emits the element; a rejected request
// goes from IDLE through ERR, which emits the error result, and back to IDLE.

module kth_permutation_unrank
    import kpu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    query_valid,
    output logic         query_ready,
    input  wire query_t  query,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    kpu_front u_front (
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .push        (push),
        .job         (front_job),
        .full        (full)
    );

    kpu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head_job)
    );

    kpu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- rtl/kpu_front.sv -----
// Front end: accepts a request, checks length and rank against n! and forms a job.
// Depends on kpu_pkg.
`default_nettype none

module kpu_front
    import kpu_pkg::*;
(
    input  wire logic   query_valid,
    output logic        query_ready,
    input  wire query_t query,
    output logic        push,
    output job_t        job,
    input  wire logic   full
);

    logic [FACT_W-1:0] total;
    logic              bad_len;
    logic              bad_rank;

    always_comb
    begin
        total    = fact_sat(query.length);
        bad_len  = (query.length == '0) || (query.length > LEN_W'(MAX_LEN));
        bad_rank = (query.rank == '0) || ({1'b0, query.rank} > total);
    end

    assign query_ready = !full;
    assign push        = query_valid && !full;
    assign job.length  = query.length;
    assign job.rem     = query.rank - RANK_W'(1);
    assign job.err     = bad_len || bad_rank;

endmodule

`default_nettype wire

// ----- rtl/kpu_queue.sv -----
// Short job queue between the front end and the digit engine.
// Depends on kpu_pkg and the assertion macro header.
`default_nettype none

`include "kth_permutation_unrank_macros.svh"

module kpu_queue
    import kpu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output job_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `KPU_ASSERT(a_queue_count, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count over depth")

endmodule

`default_nettype wire

// ----- rtl/kpu_back.sv -----
// Digit engine: walks the factorial digits of a job and emits one element per result.
// Depends on kpu_pkg and the assertion macro header.
`default_nettype none

`include "kth_permutation_unrank_macros.svh"

module kpu_back
    import kpu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    empty,
    input  wire job_t    head,
    output logic         pop,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    typedef enum logic [1:0] {IDLE, ERR, RUN} state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [RANK_W-1:0]   rem_reg, rem_next;
    logic [IDX_W-1:0]    cand_reg, cand_next;
    logic [MAX_LEN-1:0]  mask_reg, mask_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [FACT_W-1:0]   block;
    logic                can_emit;
    logic                take_block;
    logic                at_last;
    logic [MAX_LEN-1:0]  mask_set;

    // Lowest unused value index at or above start; zero if none
    function automatic logic [IDX_W-1:0] first_free(input logic [MAX_LEN-1:0] m,
                                                    input logic [IDX_W:0]     start);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_LEN - 1; i >= 0; i--)
        begin
            if (!m[i] && ((IDX_W+1)'(i) >= start))
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    always_comb
    begin
        block      = fact_sat(len_reg - pos_reg - LEN_W'(1));
        can_emit   = !out_valid_reg || result_ready;
        take_block = ({1'b0, rem_reg} >= block);
        at_last    = (pos_reg == len_reg - LEN_W'(1));
        mask_set   = mask_reg | (MAX_LEN'(1) << cand_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        cand_next      = cand_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    len_next   = head.length;
                    rem_next   = head.rem;
                    pos_next   = '0;
                    cand_next  = '0;
                    mask_next  = '0;
                    state_next = head.err ? ERR : RUN;
                end
            end
            ERR:
            begin
                if (can_emit)
                begin
                    out_valid_next        = 1'b1;
                    out_next.element      = '0;
                    out_next.out_of_range = 1'b1;
                    out_next.last         = 1'b1;
                    state_next            = IDLE;
                end
            end
            RUN:
            begin
                if (take_block)
                begin
                    // drop one block and advance to the next unused value
                    rem_next  = rem_reg - block[RANK_W-1:0];
                    cand_next = first_free(mask_reg, (IDX_W+1)'(cand_reg) + (IDX_W+1)'(1));
                end
                else if (can_emit)
                begin
                    out_valid_next        = 1'b1;
                    out_next.element      = LEN_W'(cand_reg) + LEN_W'(1);
                    out_next.out_of_range = 1'b0;
                    out_next.last         = at_last;
                    mask_next             = mask_set;
                    pos_next              = pos_reg + LEN_W'(1);
                    cand_next             = first_free(mask_set, '0);
                    if (at_last)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            cand_reg      <= '0;
            mask_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            cand_reg      <= cand_next;
            mask_reg      <= mask_next;
            out_reg       <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `KPU_ASSERT_IMPL(a_pos_in_len, state_reg == RUN, pos_reg < len_reg, "position past length")
    `KPU_ASSERT_IMPL(a_cand_free, state_reg == RUN, !mask_reg[cand_reg],
        "candidate value already used")
    `KPU_ASSERT_IMPL(a_err_shape, out_valid_reg && out_reg.out_of_range,
        out_reg.element == '0 && out_reg.last, "malformed error result")

endmodule

`default_nettype wire
